>>> rtl/bmhpq_pkg.sv
// package for the binary max-heap priority queue
// request codes, status codes and the controller state type; no dependencies
package bmhpq_pkg;

  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_INC  = 2'd2,
    REQ_DEC  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_NOKEY  = 3'd3,
    ST_REJECT = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEQ_RD,
    S_DEQ_LAST,
    S_SCAN,
    S_SCAN_CHK,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_RD2,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } state_t;

endpackage

>>> rtl/binary_max_heap_priority_queue.sv
// binary max-heap priority queue: top level, controller and slot memory
// depends on bmhpq_pkg
//
// One request at a time: busy is high from the cycle after start until the
// result strobe. Enqueue sifts the new entry up level by level; dequeue moves
// the last entry to the root and sifts it down; a key change scans the slots
// in order for the key, then sifts as above. The single-port slot memory (one
// access a cycle, registered read) sets the pace of these steps.
// The result shows for one cycle on done; the receiver cannot stall it.
module binary_max_heap_priority_queue
  import bmhpq_pkg::*;
#(
  parameter int HEAP_DEPTH    = 64,
  parameter int PRIORITY_BITS = 16,
  parameter int KEY_BITS      = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      req_type,
  input  logic [KEY_BITS-1:0]             item_key,
  input  logic signed [PRIORITY_BITS-1:0] priority_req,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [6:0]                      cfg_data,
  output logic                            done,
  output logic [2:0]                      status,
  output logic [KEY_BITS-1:0]             out_key,
  output logic signed [PRIORITY_BITS-1:0] out_priority,
  output logic [6:0]                      entry_count,
  output logic                            is_empty
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int EW = KEY_BITS + PRIORITY_BITS;

  // slot memory: key in the upper bits, priority below
  logic [EW-1:0] mem [HEAP_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [EW-1:0] mem_wdata;
  logic [EW-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  state_t state, state_next;

  logic [6:0]                      cap;
  logic [CW-1:0]                   occ;
  req_t                            req;
  logic [KEY_BITS-1:0]             key;
  logic signed [PRIORITY_BITS-1:0] prio;
  logic [CW-1:0]                   pos;
  logic [CW:0]                     child;
  logic [CW-1:0]                   last;
  logic [EW-1:0]                   lbuf;
  logic [2:0]                      st;
  logic [KEY_BITS-1:0]             okey;
  logic signed [PRIORITY_BITS-1:0] oprio;

  logic signed [PRIORITY_BITS-1:0] rd_prio, lbuf_prio;
  logic [KEY_BITS-1:0]             rd_key;
  logic [CW-1:0]                   parent;
  logic [CW:0]                     cap_eff;
  logic                            full;
  logic                            rt_ok;

  assign rd_prio   = mem_rdata[PRIORITY_BITS-1:0];
  assign rd_key    = mem_rdata[EW-1:PRIORITY_BITS];
  assign lbuf_prio = lbuf[PRIORITY_BITS-1:0];
  assign parent    = (pos - CW'(1)) >> 1;
  assign cap_eff   = ({1'b0, 7'(cap)} > (CW+1)'(HEAP_DEPTH)) ? (CW+1)'(HEAP_DEPTH)
                                                              : (CW+1)'(cap);
  assign full      = {1'b0, occ} >= cap_eff;
  // right child exists and is strictly greater
  assign rt_ok     = (child < {1'b0, last}) && ($signed(rd_prio) > lbuf_prio);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (req_t'(req_type))
            REQ_ENQ: state_next = full ? S_DONE : S_UP_RD;
            REQ_DEQ: state_next = (occ == '0) ? S_DONE : S_DEQ_RD;
            default: state_next = (occ == '0) ? S_DONE : S_SCAN;
          endcase
        end
      end
      S_DEQ_RD:   state_next = S_DEQ_LAST;
      // at most one entry left: nothing to sift
      S_DEQ_LAST: state_next = (occ <= CW'(1)) ? S_PLACE : S_DN_RD;
      S_SCAN:     state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (rd_key == key) begin
          if (req == REQ_INC) begin
            state_next = (rd_prio > prio) ? S_DONE : S_UP_RD;
          end else begin
            state_next = (rd_prio < prio) ? S_DONE : S_DN_RD;
          end
        end else if (pos + CW'(1) >= occ) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_UP_RD:  state_next = (pos == '0) ? S_PLACE : S_UP_CMP;
      S_UP_CMP: state_next = (prio > rd_prio) ? S_UP_RD : S_PLACE;
      S_DN_RD:  state_next = (child > {1'b0, last}) ? S_PLACE : S_DN_RD2;
      S_DN_RD2: state_next = S_DN_CMP;
      S_DN_CMP: begin
        if (prio >= (rt_ok ? rd_prio : lbuf_prio)) state_next = S_PLACE;
        else state_next = S_DN_RD;
      end
      S_PLACE: state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = AW'(pos);
    mem_wdata = {key, prio};
    unique case (state)
      // prefetch the last entry for a dequeue
      S_IDLE:     mem_addr = AW'(occ - CW'(1));
      S_DEQ_RD:   mem_addr = '0;
      S_DEQ_LAST: mem_addr = AW'(last);
      S_UP_RD:    mem_addr = AW'(parent);
      S_UP_CMP: begin
        if (prio > rd_prio) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
        end
      end
      S_DN_RD:  mem_addr = AW'(child);
      S_DN_RD2: mem_addr = AW'(child + 1'b1);
      S_DN_CMP: begin
        if (!(prio >= (rt_ok ? rd_prio : lbuf_prio))) begin
          mem_we    = 1'b1;
          mem_wdata = rt_ok ? mem_rdata : lbuf;
        end
      end
      S_PLACE: mem_we = 1'b1;
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      cap   <= 7'd64;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_DONE);
      if (cfg_valid && cfg_ready) cap <= cfg_data;
      unique case (state)
        S_IDLE: begin
          req   <= req_t'(req_type);
          key   <= item_key;
          prio  <= priority_req;
          okey  <= '0;
          oprio <= '0;
          st    <= ST_OK;
          if (start) begin
            unique case (req_t'(req_type))
              REQ_ENQ: begin
                pos <= occ;
                if (full) st <= ST_FULL;
                else occ <= occ + CW'(1);
              end
              REQ_DEQ: begin
                pos <= '0;
                if (occ == '0) st <= ST_EMPTY;
              end
              default: begin
                pos  <= '0;
                last <= occ - CW'(1);
                if (occ == '0) st <= ST_NOKEY;
              end
            endcase
          end
        end
        S_DEQ_RD: begin
          occ  <= occ - CW'(1);
          last <= occ - CW'(2);
          // the moved last entry becomes the sifting entry
          key  <= rd_key;
          prio <= rd_prio;
        end
        S_DEQ_LAST: begin
          okey  <= rd_key;
          oprio <= rd_prio;
          child <= (CW+1)'(1);
        end
        S_SCAN_CHK: begin
          if (rd_key == key) begin
            child <= {pos, 1'b1};
            if (req == REQ_INC ? (rd_prio > prio) : (rd_prio < prio)) st <= ST_REJECT;
          end else begin
            pos <= pos + CW'(1);
            if (pos + CW'(1) >= occ) st <= ST_NOKEY;
          end
        end
        S_UP_CMP: if (prio > rd_prio) pos <= parent;
        S_DN_RD2: lbuf <= mem_rdata;
        S_DN_CMP: begin
          if (!(prio >= (rt_ok ? rd_prio : lbuf_prio))) begin
            pos   <= rt_ok ? CW'(child + 1'b1) : CW'(child);
            child <= rt_ok ? {CW'(child + 1'b1), 1'b1} : {CW'(child), 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

  // result outputs and handshake
  assign busy         = (state != S_IDLE);
  assign cfg_ready    = (state == S_IDLE);
  assign status       = st;
  assign out_key      = okey;
  assign out_priority = oprio;
  assign entry_count  = 7'(occ);
  assign is_empty     = (occ == '0);

  // checks
  a_done_after_done_state: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> done) else $error("result strobe missing");
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, occ} <= (CW+1)'(HEAP_DEPTH)) else $error("occupancy overflow");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE)) else $error("strobe outside idle");
  a_full_keeps_occ: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> $stable(occ)) else $error("full changed occupancy");

endmodule

>>> test/tb_binary_max_heap_priority_queue.sv
// testbench for binary_max_heap_priority_queue: scoreboard against a local heap model
// depends on bmhpq_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_binary_max_heap_priority_queue;
  import bmhpq_pkg::*;

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        is_cfg;
    logic [6:0]  cap;
    req_t        req;
    logic [15:0] key;
    logic signed [15:0] prio;
  } heap_op_t;

  typedef struct packed {
    status_t     st;
    logic [15:0] key;
    logic signed [15:0] prio;
    logic [6:0]  count;
    logic        empty;
  } heap_result_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [1:0] req_type = 0;
  logic [15:0] item_key = 0;
  logic signed [15:0] priority_req = 0;
  logic cfg_valid = 0;
  logic [6:0] cfg_data = 0;
  logic busy, cfg_ready, done, is_empty;
  logic [2:0] status;
  logic [15:0] out_key;
  logic signed [15:0] out_priority;
  logic [6:0] entry_count;

  binary_max_heap_priority_queue uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .item_key(item_key), .priority_req(priority_req),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .status(status), .out_key(out_key),
    .out_priority(out_priority), .entry_count(entry_count), .is_empty(is_empty)
  );

  always #6 clk = ~clk;

  // shadow heap
  logic [15:0] hk [DEPTH];
  logic signed [15:0] hp [DEPTH];
  int occ = 0;
  int cap_reg = 64;

  heap_op_t pending_ops[$];
  heap_result_t expected_results[$];
  int errors = 0;
  int n_ops = 0, n_results = 0, n_cfg = 0;
  bit quiet_tail = 0;
  int idle_cnt = 0;
  int watchdog = 0;

  function automatic void heap_swap_in(int pos, logic [15:0] k, logic signed [15:0] p);
    hk[pos] = k;
    hp[pos] = p;
  endfunction

  function automatic void heap_up(int pos);
    logic [15:0] k;
    logic signed [15:0] p;
    int par;
    k = hk[pos];
    p = hp[pos];
    while (pos > 0) begin
      par = (pos - 1) / 2;
      if (!(p > hp[par])) break;
      heap_swap_in(pos, hk[par], hp[par]);
      pos = par;
    end
    heap_swap_in(pos, k, p);
  endfunction

  function automatic void heap_down(int pos, int last);
    logic [15:0] k;
    logic signed [15:0] p;
    int j;
    if (pos >= last) return;
    k = hk[pos];
    p = hp[pos];
    j = 2 * pos + 1;
    while (j <= last) begin
      if (j < last && hp[j] < hp[j + 1]) j++;
      if (p >= hp[j]) break;
      heap_swap_in(pos, hk[j], hp[j]);
      pos = j;
      j = 2 * pos + 1;
    end
    heap_swap_in(pos, k, p);
  endfunction

  // predict the result of one request and update the shadow heap
  function automatic heap_result_t heap_predict(heap_op_t op);
    heap_result_t r;
    int cap, idx;
    r = '0;
    r.st = ST_OK;
    cap = (cap_reg > DEPTH) ? DEPTH : cap_reg;
    case (op.req)
      REQ_ENQ: begin
        if (occ >= cap) r.st = ST_FULL;
        else begin
          heap_swap_in(occ, op.key, op.prio);
          heap_up(occ);
          occ++;
        end
      end
      REQ_DEQ: begin
        if (occ == 0) r.st = ST_EMPTY;
        else begin
          r.key = hk[0];
          r.prio = hp[0];
          heap_swap_in(0, hk[occ - 1], hp[occ - 1]);
          occ--;
          if (occ > 1) heap_down(0, occ - 1);
        end
      end
      default: begin
        idx = -1;
        for (int i = 0; i < occ; i++)
          if (idx < 0 && hk[i] == op.key) idx = i;
        if (idx < 0) r.st = ST_NOKEY;
        else if (op.req == REQ_INC) begin
          if (hp[idx] > op.prio) r.st = ST_REJECT;
          else begin
            hp[idx] = op.prio;
            heap_up(idx);
          end
        end else begin
          if (hp[idx] < op.prio) r.st = ST_REJECT;
          else begin
            hp[idx] = op.prio;
            heap_down(idx, occ - 1);
          end
        end
      end
    endcase
    r.count = occ[6:0];
    r.empty = (occ == 0);
    return r;
  endfunction

  logic [15:0] occ_shadow_keys[$];

  // key near the live set so searches mostly hit
  function automatic logic [15:0] pick_key(bit live);
    if (live && occ_shadow_keys.size() > 0 && $urandom_range(0, 9) < 8)
      return occ_shadow_keys[$urandom_range(0, occ_shadow_keys.size() - 1)];
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
  endfunction

  function automatic void push_req(req_t rq, logic [15:0] k, logic signed [15:0] p);
    heap_op_t op;
    op = '0;
    op.req = rq;
    op.key = k;
    op.prio = p;
    pending_ops.push_back(op);
    if (rq == REQ_ENQ) occ_shadow_keys.push_back(k);
  endfunction

  function automatic void push_cfg(logic [6:0] c);
    heap_op_t op;
    op = '0;
    op.is_cfg = 1;
    op.cap = c;
    pending_ops.push_back(op);
  endfunction

  function automatic logic signed [15:0] pick_prio();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  // fill the stimulus queue: directed part, random phases, then fill and drain
  initial begin
    logic [6:0] caps [6];
    caps = '{7'd64, 7'd1, 7'd2, 7'd127, 7'd7, 7'd0};
    push_req(REQ_DEQ, 16'h0000, 16'sh0000);
    push_req(REQ_INC, 16'h1234, 16'sh0001);
    push_req(REQ_ENQ, 16'hffff, 16'sh7fff);
    push_req(REQ_ENQ, 16'h0000, 16'sh8000);
    push_req(REQ_ENQ, 16'h0005, 16'sh0000);
    push_req(REQ_ENQ, 16'h0005, 16'sh0000);
    push_req(REQ_ENQ, 16'h0006, 16'sh0000);
    push_req(REQ_INC, 16'h0000, 16'sh7000);
    push_req(REQ_INC, 16'h0005, 16'sh8000);
    push_req(REQ_DEC, 16'h0005, 16'sh7fff);
    push_req(REQ_DEC, 16'h0005, 16'sh0000);
    push_req(REQ_DEC, 16'hffff, 16'sh8000);
    push_req(REQ_INC, 16'h0006, 16'sh7fff);
    push_req(REQ_DEC, 16'h0077, 16'sh0000);
    for (int i = 0; i < 7; i++) push_req(REQ_DEQ, 16'h0, 16'sh0);
    for (int ph = 0; ph < 6; ph++) begin
      push_cfg(caps[ph]);
      for (int i = 0; i < 110; i++) begin
        int w;
        w = $urandom_range(0, 9);
        if (w < 4) push_req(REQ_ENQ, pick_key(0), pick_prio());
        else if (w < 6) push_req(REQ_DEQ, 16'($urandom), 16'($urandom));
        else if (w < 8) push_req(REQ_INC, pick_key(1), pick_prio());
        else push_req(REQ_DEC, pick_key(1), pick_prio());
      end
    end
    // enqueue until full then drain, with a lowered capacity on the way
    push_cfg(7'd64);
    for (int i = 0; i < 66; i++) push_req(REQ_ENQ, pick_key(0), pick_prio());
    push_cfg(7'd3);
    push_req(REQ_ENQ, 16'h1, 16'sh1);
    for (int i = 0; i < 66; i++) push_req(REQ_DEQ, 16'h0, 16'sh0);
  end

  // driver: launch requests and config writes when idle
  always @(posedge clk) begin
    heap_op_t op;
    if (rst) begin
      start <= 0;
      cfg_valid <= 0;
    end else if (cfg_valid) begin
      if (cfg_ready) begin
        cap_reg = cfg_data;
        n_cfg++;
        cfg_valid <= 0;
      end
    end else if (start) begin
      if (!busy) begin
        start <= 0;
      end
    end else if (idle_cnt > 0) begin
      idle_cnt--;
    end else if (pending_ops.size() > 0 && !busy) begin
      op = pending_ops[0];
      if (op.is_cfg) begin
        // wait until the block has drained
        if (expected_results.size() == 0 && !done) begin
          void'(pending_ops.pop_front());
          cfg_data <= op.cap;
          cfg_valid <= 1;
        end
      end else begin
        void'(pending_ops.pop_front());
        req_type <= op.req;
        item_key <= op.key;
        priority_req <= op.prio;
        start <= 1;
        if (!quiet_tail && $urandom_range(0, 3) == 0) idle_cnt = $urandom_range(1, 8);
      end
    end
    if (pending_ops.size() < 60) quiet_tail = 1;
  end

  // capture accepted requests into the prediction queue
  always @(posedge clk) begin
    heap_op_t op;
    if (!rst && start && !busy) begin
      op = '0;
      op.req = req_t'(req_type);
      op.key = item_key;
      op.prio = priority_req;
      expected_results.push_back(heap_predict(op));
      n_ops++;
    end
  end

  // monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    heap_result_t e;
    if (!rst && done) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0d", status);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, status); errors++;
        end
        if (out_key !== e.key) begin
          $error("out_key expected %0h actual %0h", e.key, out_key); errors++;
        end
        if (out_priority !== e.prio) begin
          $error("out_priority expected %0d actual %0d", e.prio, out_priority); errors++;
        end
        if (entry_count !== e.count) begin
          $error("entry_count expected %0d actual %0d", e.count, entry_count); errors++;
        end
        if (is_empty !== e.empty) begin
          $error("is_empty expected %0d actual %0d", e.empty, is_empty); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("tb_binary_max_heap_priority_queue NOT OK");
      $finish;
    end
  end

  // reset, then wait for the stimulus to drain
  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    #1;
    wait (pending_ops.size() == 0 && !start && !cfg_valid && expected_results.size() == 0);
    repeat (300) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d capacity writes", n_ops, n_results, n_cfg);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_binary_max_heap_priority_queue OK");
    end else begin
      $display("tb_binary_max_heap_priority_queue NOT OK");
    end
    $finish;
  end

endmodule
